// ----- rtl/poeq_pkg.sv -----
// Package for the per-object output event queue.
// Holds command/status codes, sizing constants, command record and state types.
// No dependencies.
`default_nettype none
package poeq_pkg;

  localparam int NUM_OBJECTS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int MAX_RESULTS     = 64;
  localparam int CMD_W           = 3;
  localparam int OBJ_W           = 4;
  localparam int DATA_W          = 32;
  localparam int CNT_W           = 7;
  localparam int STAT_W          = 2;
  localparam logic [DATA_W-1:0] ALL_ONES = '1;

  localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_COLLECT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_COLL_ALL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ROLLBACK = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SIZE     = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // one classified command passed from the front to the back
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic              bad_obj;
    logic [OBJ_W-1:0]  obj;
    logic [DATA_W-1:0] handle;
    logic [DATA_W-1:0] etime;
    logic [DATA_W-1:0] thr;
  } poeq_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_INS, S_CREAD, S_CWAIT, S_CCHK,
    S_RREAD, S_RWAIT, S_RCHK, S_RDONE, S_EMIT
  } poeq_state_t;

endpackage
`default_nettype wire

// ----- rtl/per_object_output_event_queue.sv -----
// Top level of the per-object output event queue.
// Instantiates poeq_front and poeq_back; depends on poeq_pkg.
//
// Usage: commands enter through a queue-style port (in_push / in_full) and
// results leave through one (out_pop / out_empty). A two-entry command queue
// lets the front take commands while the back works.
// Size query and error results are emitted from dispatch; an insert passes
// through one more state first. Fossil collect reads, waits on and checks
// each popped entry in turn; collect-all walks every object the same way,
// skipping the wait for an empty one. Rollback removes one entry at a time
// (registered read of the entry store, then compare), up to 64 per command.
// Each removed entry is published when the next check decides whether it is
// the final one, so last is set on the final result.
// A held result waits on the output register; the back starts no new command
// and a rollback walk stalls until it is popped, and the command queue then
// fills and raises in_full. Reset clears the queue pointers and counts; entry
// contents are not cleared.
`default_nettype none
module per_object_output_event_queue import poeq_pkg::*; #(
  parameter int NUM_OBJECTS = NUM_OBJECTS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire logic [CMD_W-1:0]  in_command,
  input  wire logic [OBJ_W-1:0]  in_object_id,
  input  wire logic [DATA_W-1:0] in_event_handle,
  input  wire logic [DATA_W-1:0] in_event_time,
  input  wire logic [DATA_W-1:0] in_threshold_time,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output logic [STAT_W-1:0]      out_status,
  output logic [DATA_W-1:0]      out_out_handle,
  output logic [DATA_W-1:0]      out_out_time,
  output logic [DATA_W-1:0]      out_earliest_time,
  output logic [CNT_W-1:0]       out_queue_count,
  output logic                   out_last
);
  logic      cmd_valid, cmd_take;
  poeq_cmd_t cmd_data;

  poeq_front #(.NUM_OBJECTS(NUM_OBJECTS)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_command, .in_object_id,
    .in_event_handle, .in_event_time, .in_threshold_time,
    .cmd_valid, .cmd_data, .cmd_take
  );

  poeq_back #(.NUM_OBJECTS(NUM_OBJECTS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_data, .cmd_take, .out_empty, .out_pop,
    .out_status, .out_out_handle, .out_out_time, .out_earliest_time,
    .out_queue_count, .out_last
  );

  // a reported count never exceeds the queue depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_queue_count <= CNT_W'(QUEUE_DEPTH)))
    else $error("queue count out of range");

  // a rollback entry result carries ok status
  a_st: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_last) |-> (out_status == ST_OK))
    else $error("non-final result with bad status");

  // the back never takes a command while none waits
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> cmd_valid)
    else $error("command taken from empty queue");
endmodule
`default_nettype wire

// ----- rtl/poeq_front.sv -----
// Front end: accepts commands and queues them, classified, for the back end.
// Depends on poeq_pkg.
`default_nettype none
module poeq_front import poeq_pkg::*; #(
  parameter int NUM_OBJECTS = NUM_OBJECTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire logic [CMD_W-1:0]  in_command,
  input  wire logic [OBJ_W-1:0]  in_object_id,
  input  wire logic [DATA_W-1:0] in_event_handle,
  input  wire logic [DATA_W-1:0] in_event_time,
  input  wire logic [DATA_W-1:0] in_threshold_time,
  output logic                   cmd_valid,
  output poeq_cmd_t              cmd_data,
  input  wire logic              cmd_take
);
  // two-entry command queue
  poeq_cmd_t  q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  poeq_cmd_t  nc;
  logic       do_push, do_pop;

  // classify the incoming command
  always_comb begin
    nc.cmd     = in_command;
    nc.bad_obj = ({28'd0, in_object_id} >= NUM_OBJECTS);
    nc.obj     = in_object_id;
    nc.handle  = in_event_handle;
    nc.etime   = in_event_time;
    nc.thr     = in_threshold_time;
  end

  assign in_full   = (cnt_r == 2'd2);
  assign do_push   = in_push && !in_full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign do_pop    = cmd_take && cmd_valid;
  assign cmd_data  = q_r[rp_r];

  // hold payload
  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= nc;
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule
`default_nettype wire

// ----- rtl/poeq_back.sv -----
// Back end: executes commands against the per-object queues, emits results.
// Depends on poeq_pkg.
`default_nettype none
module poeq_back import poeq_pkg::*; #(
  parameter int NUM_OBJECTS = NUM_OBJECTS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cmd_valid,
  input  poeq_cmd_t               cmd_data,
  output logic                    cmd_take,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic [STAT_W-1:0]       out_status,
  output logic [DATA_W-1:0]       out_out_handle,
  output logic [DATA_W-1:0]       out_out_time,
  output logic [DATA_W-1:0]       out_earliest_time,
  output logic [CNT_W-1:0]        out_queue_count,
  output logic                    out_last
);
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OW = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
  localparam int AW = PW + OW;
  localparam int KW = $clog2(QUEUE_DEPTH + 1);
  localparam int RW = $clog2(MAX_RESULTS + 1);

  // entry store
  logic [DATA_W-1:0] mem_t [NUM_OBJECTS*QUEUE_DEPTH];
  logic [DATA_W-1:0] mem_h [NUM_OBJECTS*QUEUE_DEPTH];
  logic [PW-1:0]     head_r [NUM_OBJECTS];
  logic [KW-1:0]     cnt_r  [NUM_OBJECTS];

  poeq_state_t st_r, st_nxt;
  poeq_cmd_t   c_r;
  logic [OW-1:0] o_r, o_nxt;
  logic [RW-1:0] n_r, n_nxt;
  logic [DATA_W-1:0] best_r, best_nxt;
  logic [DATA_W-1:0] rd_t_r, rd_h_r;
  logic [AW-1:0] raddr, waddr;
  logic          we;

  // output register
  logic              ov_r, ov_nxt;
  logic [STAT_W-1:0] os_r, os_nxt;
  logic [DATA_W-1:0] oh_r, oh_nxt, ot_r, ot_nxt, oe_r, oe_nxt;
  logic [CNT_W-1:0]  oc_r, oc_nxt;
  logic              ol_r, ol_nxt;

  // removed rollback entry held until it is known whether it is the final one
  logic [DATA_W-1:0] ph_r, ph_nxt, pt_r, pt_nxt;
  logic [CNT_W-1:0]  pc_r, pc_nxt;

  // per-object update
  logic          hupd, cupd;
  logic [PW-1:0] h_nxt;
  logic [KW-1:0] k_nxt;

  logic [PW-1:0] head_c;
  logic [KW-1:0] cnt_c;
  logic [PW-1:0] tail_idx, last_idx;

  assign head_c   = head_r[o_r];
  assign cnt_c    = cnt_r[o_r];
  assign tail_idx = PW'((KW'(head_c) + cnt_c) % QUEUE_DEPTH);
  assign last_idx = PW'((KW'(head_c) + cnt_c + KW'(QUEUE_DEPTH - 1)) % QUEUE_DEPTH);
  assign waddr    = {o_r, tail_idx};

  assign out_empty         = !ov_r;
  assign out_status        = os_r;
  assign out_out_handle    = oh_r;
  assign out_out_time      = ot_r;
  assign out_earliest_time = oe_r;
  assign out_queue_count   = oc_r;
  assign out_last          = ol_r;

  // sequencer
  always_comb begin
    st_nxt = st_r; o_nxt = o_r; n_nxt = n_r; best_nxt = best_r;
    cmd_take = 1'b0; we = 1'b0; hupd = 1'b0; cupd = 1'b0;
    h_nxt = head_c; k_nxt = cnt_c;
    raddr = {o_r, head_c};
    ov_nxt = ov_r && !out_pop;
    os_nxt = os_r; oh_nxt = oh_r; ot_nxt = ot_r; oe_nxt = oe_r;
    oc_nxt = oc_r; ol_nxt = ol_r;
    ph_nxt = ph_r; pt_nxt = pt_r; pc_nxt = pc_r;
    case (st_r)
      // start a command only once the output register is free
      S_IDLE: begin
        if (cmd_valid && (!ov_r || out_pop)) begin
          cmd_take = 1'b1;
          o_nxt = (cmd_data.cmd == CMD_COLL_ALL) ? '0 : OW'(cmd_data.obj);
          n_nxt = '0; best_nxt = ALL_ONES;
          st_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (c_r.cmd == CMD_COLL_ALL) st_nxt = S_CREAD;
        else if (c_r.bad_obj) begin
          os_nxt = ST_EMPTY; oc_nxt = '0; st_nxt = S_EMIT;
        end else begin
          case (c_r.cmd)
            CMD_INSERT:   st_nxt = S_INS;
            CMD_COLLECT:  st_nxt = S_CREAD;
            CMD_ROLLBACK: st_nxt = S_RREAD;
            CMD_SIZE: begin
              os_nxt = ST_OK; oc_nxt = CNT_W'(cnt_c); st_nxt = S_EMIT;
            end
            default: begin
              os_nxt = ST_EMPTY; oc_nxt = CNT_W'(cnt_c); st_nxt = S_EMIT;
            end
          endcase
        end
        oh_nxt = '0; ot_nxt = '0; oe_nxt = '0; ol_nxt = 1'b1;
      end
      S_INS: begin
        if (cnt_c >= KW'(QUEUE_DEPTH)) begin
          os_nxt = ST_FULL; oc_nxt = CNT_W'(cnt_c);
        end else begin
          we = 1'b1; cupd = 1'b1; k_nxt = cnt_c + 1'b1;
          os_nxt = ST_OK; oc_nxt = CNT_W'(k_nxt);
        end
        st_nxt = S_EMIT;
      end
      // collect: read head, compare, pop
      S_CREAD: begin
        raddr = {o_r, head_c};
        st_nxt = (cnt_c == '0) ? S_CCHK : S_CWAIT;
      end
      S_CWAIT: st_nxt = S_CCHK;
      S_CCHK: begin
        if (cnt_c != '0 && rd_t_r < c_r.thr) begin
          hupd = 1'b1; cupd = 1'b1;
          h_nxt = PW'((KW'(head_c) + 1'b1) % QUEUE_DEPTH);
          k_nxt = cnt_c - 1'b1;
          st_nxt = S_CREAD;
        end else begin
          if (c_r.cmd == CMD_COLL_ALL) begin
            if (cnt_c != '0 && rd_t_r < best_r) best_nxt = rd_t_r;
            if (32'(o_r) == NUM_OBJECTS - 1) begin
              os_nxt = ST_OK; oc_nxt = '0;
              oe_nxt = (cnt_c != '0 && rd_t_r < best_r) ? rd_t_r : best_r;
              st_nxt = S_EMIT;
            end else begin
              o_nxt = o_r + 1'b1; st_nxt = S_CREAD;
            end
          end else begin
            os_nxt = ST_OK; oc_nxt = CNT_W'(cnt_c);
            oe_nxt = (cnt_c == '0) ? ALL_ONES : rd_t_r;
            st_nxt = S_EMIT;
          end
        end
      end
      // rollback: read tail, compare; a removed entry is published once the
      // next check tells whether it is the final one
      S_RREAD: begin
        raddr = {o_r, last_idx};
        if (!ov_r || out_pop)
          st_nxt = (cnt_c == '0 || n_r == RW'(MAX_RESULTS)) ? S_RDONE : S_RWAIT;
      end
      S_RWAIT: begin
        raddr = {o_r, last_idx};
        st_nxt = S_RCHK;
      end
      S_RCHK: begin
        if (rd_t_r >= c_r.thr) begin
          cupd = 1'b1; k_nxt = cnt_c - 1'b1;
          if (n_r != '0) begin
            ov_nxt = 1'b1; os_nxt = ST_OK; oh_nxt = ph_r; ot_nxt = pt_r;
            oe_nxt = '0; oc_nxt = pc_r; ol_nxt = 1'b0;
          end
          ph_nxt = rd_h_r; pt_nxt = rd_t_r; pc_nxt = CNT_W'(k_nxt);
          n_nxt = n_r + 1'b1;
          st_nxt = S_RREAD;
        end else st_nxt = S_RDONE;
      end
      S_RDONE: begin
        if (n_r != '0) begin
          ov_nxt = 1'b1; os_nxt = ST_OK; oh_nxt = ph_r; ot_nxt = pt_r;
          oe_nxt = '0; oc_nxt = pc_r; ol_nxt = 1'b1; st_nxt = S_IDLE;
        end else begin
          os_nxt = ST_EMPTY; oh_nxt = '0; ot_nxt = '0; oe_nxt = '0;
          oc_nxt = CNT_W'(cnt_c); ol_nxt = 1'b1; st_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!ov_r || out_pop) begin
          ov_nxt = 1'b1; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0;
      for (int i = 0; i < NUM_OBJECTS; i++) begin
        head_r[i] <= '0; cnt_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt;
      if (hupd) head_r[o_r] <= h_nxt;
      if (cupd) cnt_r[o_r]  <= k_nxt;
    end
  end

  // payload and store
  always_ff @(posedge clk) begin
    if (cmd_take) c_r <= cmd_data;
    o_r <= o_nxt; n_r <= n_nxt; best_r <= best_nxt;
    os_r <= os_nxt; oh_r <= oh_nxt; ot_r <= ot_nxt; oe_r <= oe_nxt;
    oc_r <= oc_nxt;
    ol_r <= ol_nxt;
    ph_r <= ph_nxt; pt_r <= pt_nxt; pc_r <= pc_nxt;
    rd_t_r <= mem_t[raddr];
    rd_h_r <= mem_h[raddr];
    if (we) begin
      mem_t[waddr] <= c_r.etime;
      mem_h[waddr] <= c_r.handle;
    end
  end
endmodule
`default_nettype wire
